@@ hdl/sbcd_pkg.sv @@
// Shared constants and types for the signalling bit change detector.
package sbcd_pkg;

	localparam int NUM_AREAS     = 3;
	localparam int ADDRESS_SPACE = 256;
	localparam int CNT_W         = 9;
	localparam int ENTRY_W       = 9;
	localparam int UNK_BIT       = 8;
	localparam int AW            = $clog2(ADDRESS_SPACE);
	localparam int DEPTH         = NUM_AREAS * ADDRESS_SPACE;
	localparam int IW            = $clog2(DEPTH);

	localparam logic [ENTRY_W-1:0] ENTRY_UNKNOWN = ENTRY_W'(1) << UNK_BIT;

	localparam logic KIND_CHANGE = 1'b0;
	localparam logic KIND_RANGE  = 1'b1;

	localparam logic [1:0] REG_AREA0_COUNT = 2'd0;
	localparam logic [1:0] REG_AREA1_COUNT = 2'd1;
	localparam logic [1:0] REG_AREA2_COUNT = 2'd2;

	typedef logic [NUM_AREAS-1:0][CNT_W-1:0] count_arr_t;

	localparam count_arr_t COUNT_RESET = {9'd15, 9'd0, 9'd8};

	typedef struct packed {
		logic        kind;
		logic [1:0]  area;
		logic [15:0] addr;
		logic [2:0]  bit_index;
		logic        bit_value;
	} result_t;

	typedef struct packed {
		logic               we;
		logic [IW-1:0]      waddr;
		logic [ENTRY_W-1:0] wdata;
		logic [IW-1:0]      raddr;
	} mem_req_t;

endpackage

@@ hdl/signal_bit_change_detector_core.sv @@
// Top level of the signalling bit change detector.
// After reset the block marks all 768 image entries (3 areas x 256 bytes) unknown and takes no
// input transaction meanwhile; count writes are taken at any time. Items are handled one at a
// time from a single image memory with a registered read port. Each in-range byte goes through
// range check and read, compare and write back, then an emit step that gives one changed-bit
// event per differing bit (every bit while the entry is unknown) before advancing; an
// out-of-range byte gives one range event instead. An update covers one byte and a refresh
// four, and each item ends with a final flush. The final event of an item is held back so it
// can carry last; an item whose bytes all match the image gives no result transaction.
module signal_bit_change_detector_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [sbcd_pkg::CNT_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       func,
	input  logic [1:0]                 area,
	input  logic [15:0]                address,
	input  logic [31:0]                data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       kind,
	output logic [1:0]                 event_area,
	output logic [15:0]                byte_address,
	output logic [2:0]                 bit_index,
	output logic                       bit_value,
	output logic                       last
);

	sbcd_pkg::count_arr_t                counts;
	sbcd_pkg::result_t                   res;
	sbcd_pkg::mem_req_t                  mem_req;
	logic [sbcd_pkg::ENTRY_W-1:0]        mem_rdata;

	sbcd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.counts    (counts)
	);

	sbcd_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.counts    (counts),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.area      (area),
		.address   (address),
		.data      (data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res),
		.out_last  (last),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	sbcd_ram #(
		.WIDTH (sbcd_pkg::ENTRY_W),
		.DEPTH (sbcd_pkg::DEPTH)
	) u_image (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	assign kind         = res.kind;
	assign event_area   = res.area;
	assign byte_address = res.addr;
	assign bit_index    = res.bit_index;
	assign bit_value    = res.bit_value;

endmodule

@@ hdl/sbcd_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
module sbcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/sbcd_cfg.sv @@
// Area address count registers and their write port.
module sbcd_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [sbcd_pkg::CNT_W-1:0] cfg_data,
	output sbcd_pkg::count_arr_t       counts
);

	sbcd_pkg::count_arr_t counts_q;

	assign cfg_ready = 1'b1;
	assign counts    = counts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q <= sbcd_pkg::COUNT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sbcd_pkg::REG_AREA0_COUNT: counts_q[0] <= cfg_data;
				sbcd_pkg::REG_AREA1_COUNT: counts_q[1] <= cfg_data;
				sbcd_pkg::REG_AREA2_COUNT: counts_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/sbcd_engine.sv @@
// Byte sequencer: image clear after reset, range check, read-compare-write of the image, event emission.
module sbcd_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sbcd_pkg::count_arr_t     counts,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic [1:0]               area,
	input  logic [15:0]              address,
	input  logic [31:0]              data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output sbcd_pkg::result_t        out_res,
	output logic                     out_last,
	output sbcd_pkg::mem_req_t       mem_req,
	input  logic [sbcd_pkg::ENTRY_W-1:0] mem_rdata
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_CMP   = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;

	localparam int IW = sbcd_pkg::IW;

	logic [2:0]        state_q;
	logic [IW-1:0]     clr_q;
	logic              func_q;
	logic [1:0]        area_q;
	logic [15:0]       addr_q;
	logic [31:0]       data_q;
	logic [1:0]        byte_q;
	logic [7:0]        mask_q;
	logic              pend_valid_q;
	sbcd_pkg::result_t pend_q;
	logic              out_valid_q;
	sbcd_pkg::result_t out_q;
	logic              out_last_q;

	logic [15:0]                 byte_addr;
	logic [7:0]                  cur_byte;
	logic [sbcd_pkg::CNT_W-1:0]  cnt;
	logic                        in_range;
	logic                        last_byte;
	logic [IW-1:0]               idx;
	logic [7:0]                  mask_new;
	logic [2:0]                  sel;
	logic                        gen_valid;
	sbcd_pkg::result_t           gen;
	logic                        out_free;
	logic                        fire_gen;
	logic                        push;
	logic                        adv;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

	assign byte_addr = addr_q + 16'(byte_q);
	assign cur_byte  = func_q ? data_q[{~byte_q, 3'b000} +: 8] : data_q[7:0];
	assign last_byte = !func_q || (byte_q == 2'd3);
	assign idx       = IW'(area_q) * IW'(sbcd_pkg::ADDRESS_SPACE)
	                 + IW'(byte_addr[sbcd_pkg::AW-1:0]);

	always_comb begin
		cnt = '0;
		for (int i = 0; i < sbcd_pkg::NUM_AREAS; i++) begin
			if (area_q == 2'(i)) begin
				cnt = counts[i];
			end
		end
	end

	assign in_range = (byte_addr < 16'(sbcd_pkg::ADDRESS_SPACE)) && (byte_addr < 16'(cnt));

	assign mask_new = mem_rdata[sbcd_pkg::UNK_BIT] ? 8'hff : (mem_rdata[7:0] ^ cur_byte);

	always_comb begin
		sel = '0;
		for (int i = 7; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = 3'(i);
			end
		end
	end

	always_comb begin
		gen_valid     = 1'b0;
		gen.kind      = sbcd_pkg::KIND_CHANGE;
		gen.area      = area_q;
		gen.addr      = byte_addr;
		gen.bit_index = '0;
		gen.bit_value = 1'b0;
		if (state_q == ST_CHECK && !in_range) begin
			gen_valid = 1'b1;
			gen.kind  = sbcd_pkg::KIND_RANGE;
		end else if (state_q == ST_EMIT && mask_q != '0) begin
			gen_valid     = 1'b1;
			gen.bit_index = sel;
			gen.bit_value = cur_byte[sel];
		end
	end

	// one result is held back so that last can be set once the item is done
	assign out_free = !out_valid_q || out_ready;
	assign fire_gen = gen_valid && (!pend_valid_q || out_free);
	assign push     = pend_valid_q && out_free && (fire_gen || state_q == ST_FLUSH);
	assign adv      = (state_q == ST_CHECK && !in_range && fire_gen)
	               || (state_q == ST_EMIT && mask_q == '0);

	always_comb begin
		mem_req.raddr = idx;
		mem_req.we    = 1'b0;
		mem_req.waddr = idx;
		mem_req.wdata = {1'b0, cur_byte};
		if (state_q == ST_CLEAR) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = clr_q;
			mem_req.wdata = sbcd_pkg::ENTRY_UNKNOWN;
		end else if (state_q == ST_CMP) begin
			mem_req.we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			byte_q       <= '0;
			mask_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(sbcd_pkg::DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						byte_q  <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (in_range) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					mask_q  <= mask_new;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (fire_gen) begin
						mask_q[sel] <= 1'b0;
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (adv) begin
				if (last_byte) begin
					state_q <= ST_FLUSH;
				end else begin
					byte_q  <= byte_q + 2'd1;
					state_q <= ST_CHECK;
				end
			end

			if (fire_gen) begin
				pend_valid_q <= 1'b1;
			end else if (push) begin
				pend_valid_q <= 1'b0;
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			func_q <= func;
			area_q <= area;
			addr_q <= address;
			data_q <= data;
		end
		if (fire_gen) begin
			pend_q <= gen;
		end
		if (push) begin
			out_q      <= pend_q;
			out_last_q <= (state_q == ST_FLUSH);
		end
	end

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("held result left over at item end");

	a_accept_starts_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_CHECK)
		else $error("accepted transaction did not start a range check");

	a_write_clears_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we && state_q != ST_CLEAR |-> !mem_req.wdata[sbcd_pkg::UNK_BIT])
		else $error("image write left the unknown flag set");

	a_cmp_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |=> state_q == ST_EMIT && mask_q == $past(mask_new))
		else $error("compare result not captured");

endmodule
